// ----- rtl/bmc_pkg.sv -----
// types, constants and row formatting helpers shared by the maze carver
`timescale 1ns / 1ps

package bmc_pkg;

    localparam int N          = 16;
    localparam int NCELLS     = N * N;
    localparam int POS_W      = $clog2(N);
    localparam int CELL_W     = 2 * POS_W;
    localparam int CNT_W      = $clog2(NCELLS + 1);
    localparam int GRID_W     = 2 * N + 1;
    localparam int COORD_W    = 4;
    localparam int GIDX_W     = 6;
    localparam int ROW_BITS_W = 33;

    typedef logic [N-1:0]          row_t;
    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [CELL_W-1:0]     cell_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [COORD_W-1:0]    coord_t;
    typedef logic [GIDX_W-1:0]     gidx_t;
    typedef logic [ROW_BITS_W-1:0] bits_t;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_ROW    = 1'b1;

    localparam logic [1:0] ST_MOVED   = 2'd0;
    localparam logic [1:0] ST_BLOCKED = 2'd1;
    localparam logic [1:0] ST_BACK    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic         opcode;
        logic [3:0]   start_col;
        logic [3:0]   start_row;
        logic [1:0]   draw;
    } bmc_in_t;

    typedef struct packed {
        logic         kind;
        logic [1:0]   status;
        logic [3:0]   cur_col;
        logic [3:0]   cur_row;
        logic         finished;
        logic [5:0]   row_index;
        logic [32:0]  row_bits;
        logic         last;
    } bmc_out_t;

    typedef enum logic [2:0] {RD_NONE, RD_CUR, RD_UP, RD_DN, RD_OPEN, RD_BM} map_rd_t;
    typedef enum logic [1:0] {CAP_NONE, CAP_CUR, CAP_UP, CAP_DN} cap_t;
    typedef enum logic [2:0] {EM_NONE, EM_REPORT, EM_TOP, EM_ODD, EM_EVEN} emit_t;

    typedef struct packed {
        logic         accept;
        logic         start;
        map_rd_t      map_rd;
        cap_t         cap;
        logic         stk_rd;
        logic         move;
        logic         pop;
        emit_t        emit;
        logic [1:0]   status;
        logic         last;
        logic         bm_clr;
        logic         bm_inc;
    } bmc_ctl_t;

    typedef struct packed {
        logic active;
        logic any_free;
        logic blocked;
        logic stk_empty;
        logic finished;
        logic slot_free;
        logic bm_last;
    } bmc_sts_t;

    // cell row r as grid row 2r+1: cells and the openings to their right
    function automatic bits_t odd_row(input row_t vis, input row_t rgt);
        logic [GRID_W-1:0] b;
        b = '0;
        for (int c = 0; c < N; c++)
        begin
            b[2*c+1] = vis[c];
            if (c < N - 1)
            begin
                b[2*c+2] = rgt[c];
            end
        end
        return bits_t'(b);
    endfunction

    // grid row 2r+2: openings below the cells of row r
    function automatic bits_t even_row(input row_t dwn);
        logic [GRID_W-1:0] b;
        b = '0;
        for (int c = 0; c < N; c++)
        begin
            b[2*c+1] = dwn[c];
        end
        return bits_t'(b);
    endfunction

endpackage

// ----- rtl/bmc_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module bmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bmc_ctrl.sv -----
// sequencing state machine of the maze carver
`timescale 1ns / 1ps

module bmc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_opcode,
    output logic              cmd_stall,
    input  bmc_pkg::bmc_sts_t sts,
    output bmc_pkg::bmc_ctl_t ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_N_CUR,
        S_N_UP,
        S_N_DN,
        S_DECIDE,
        S_MOVE,
        S_POP,
        S_REPORT,
        S_BM_TOP,
        S_BM_RD,
        S_BM_ODD,
        S_BM_EVEN
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] status_reg, status_next;

    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        ctl         = '0;
        ctl.map_rd  = bmc_pkg::RD_NONE;
        ctl.cap     = bmc_pkg::CAP_NONE;
        ctl.emit    = bmc_pkg::EM_NONE;
        ctl.status  = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.accept = 1'b1;
                    if (cmd_opcode == bmc_pkg::OP_START)
                    begin
                        ctl.start   = 1'b1;
                        status_next = bmc_pkg::ST_MOVED;
                        state_next  = S_REPORT;
                    end
                    else if (!sts.active)
                    begin
                        status_next = bmc_pkg::ST_IGNORED;
                        state_next  = S_REPORT;
                    end
                    else
                    begin
                        ctl.map_rd = bmc_pkg::RD_CUR;
                        state_next = S_N_CUR;
                    end
                end
            end
            S_N_CUR:
            begin
                ctl.cap    = bmc_pkg::CAP_CUR;
                ctl.map_rd = bmc_pkg::RD_UP;
                state_next = S_N_UP;
            end
            S_N_UP:
            begin
                ctl.cap    = bmc_pkg::CAP_UP;
                ctl.map_rd = bmc_pkg::RD_DN;
                state_next = S_N_DN;
            end
            S_N_DN:
            begin
                ctl.cap    = bmc_pkg::CAP_DN;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!sts.any_free)
                begin
                    status_next = bmc_pkg::ST_BACK;
                    if (sts.stk_empty)
                    begin
                        state_next = S_REPORT;
                    end
                    else
                    begin
                        ctl.stk_rd = 1'b1;
                        state_next = S_POP;
                    end
                end
                else if (sts.blocked)
                begin
                    status_next = bmc_pkg::ST_BLOCKED;
                    state_next  = S_REPORT;
                end
                else
                begin
                    ctl.map_rd  = bmc_pkg::RD_OPEN;
                    status_next = bmc_pkg::ST_MOVED;
                    state_next  = S_MOVE;
                end
            end
            S_MOVE:
            begin
                ctl.move   = 1'b1;
                state_next = S_REPORT;
            end
            S_POP:
            begin
                ctl.pop    = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                // a move that visits the last cell is followed by the bitmap
                ctl.last = !(status_reg == bmc_pkg::ST_MOVED && sts.finished);
                if (sts.slot_free)
                begin
                    ctl.emit   = bmc_pkg::EM_REPORT;
                    state_next = ctl.last ? S_IDLE : S_BM_TOP;
                end
            end
            S_BM_TOP:
            begin
                if (sts.slot_free)
                begin
                    ctl.emit   = bmc_pkg::EM_TOP;
                    ctl.bm_clr = 1'b1;
                    state_next = S_BM_RD;
                end
            end
            S_BM_RD:
            begin
                ctl.map_rd = bmc_pkg::RD_BM;
                state_next = S_BM_ODD;
            end
            S_BM_ODD:
            begin
                if (sts.slot_free)
                begin
                    ctl.emit   = bmc_pkg::EM_ODD;
                    state_next = S_BM_EVEN;
                end
            end
            S_BM_EVEN:
            begin
                if (sts.slot_free)
                begin
                    ctl.emit = bmc_pkg::EM_EVEN;
                    if (sts.bm_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl.bm_inc = 1'b1;
                        state_next = S_BM_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= bmc_pkg::ST_MOVED;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

// ----- rtl/bmc_dp.sv -----
// maze datapath: map and stack memories, position, counters, result register
`timescale 1ns / 1ps

module bmc_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  bmc_pkg::bmc_in_t  cmd,
    input  logic              rpt_stall,
    output logic              rpt_valid,
    output bmc_pkg::bmc_out_t rpt,
    input  bmc_pkg::bmc_ctl_t ctl,
    output bmc_pkg::bmc_sts_t sts
);

    bmc_pkg::pos_t   cur_row_reg, cur_col_reg;
    bmc_pkg::pos_t   bm_r_reg;
    logic [1:0]      draw_reg;
    bmc_pkg::cnt_t   cnt_reg, depth_reg, depth_dec;
    logic            active_reg;
    bmc_pkg::row_t   row_cur_reg, row_up_reg, row_dn_reg;
    bmc_pkg::row_t   vis_vld_reg, rgt_vld_reg, dwn_vld_reg;
    logic            vis_v_reg, rgt_v_reg, dwn_v_reg;
    bmc_pkg::bmc_out_t out_reg, out_next;
    logic            out_vld_reg;

    bmc_pkg::row_t   vis_rdata, rgt_rdata, dwn_rdata;
    bmc_pkg::row_t   vis_row, rgt_row, dwn_row;
    bmc_pkg::pos_t   map_raddr;
    logic            map_re;
    logic            vis_we, rgt_we, dwn_we;
    bmc_pkg::pos_t   vis_waddr, open_waddr;
    bmc_pkg::row_t   vis_wdata, rgt_wdata, dwn_wdata;
    bmc_pkg::row_t   col_oh, lf_oh, rt_oh;
    bmc_pkg::pos_t   row_up, row_dn, st_col, st_row, nb_row, nb_col;
    logic            stk_we;
    bmc_pkg::cell_t  stk_rdata;
    logic            up_free, dn_free, lf_free, rt_free, drawn_free;
    logic            at_top, at_bot, at_lft, at_rgt;
    logic [bmc_pkg::POS_W+1:0] idx_odd, idx_even;

    // rows never written since the last start read as all zero
    assign vis_row = vis_rdata & {bmc_pkg::N{vis_v_reg}};
    assign rgt_row = rgt_rdata & {bmc_pkg::N{rgt_v_reg}};
    assign dwn_row = dwn_rdata & {bmc_pkg::N{dwn_v_reg}};

    assign at_top = (cur_row_reg == '0);
    assign at_bot = (cur_row_reg == bmc_pkg::pos_t'(bmc_pkg::N - 1));
    assign at_lft = (cur_col_reg == '0);
    assign at_rgt = (cur_col_reg == bmc_pkg::pos_t'(bmc_pkg::N - 1));
    assign row_up = cur_row_reg - bmc_pkg::pos_t'(1);
    assign row_dn = cur_row_reg + bmc_pkg::pos_t'(1);

    assign col_oh = bmc_pkg::row_t'(1) << cur_col_reg;
    assign lf_oh  = bmc_pkg::row_t'(1) << (cur_col_reg - bmc_pkg::pos_t'(1));
    assign rt_oh  = bmc_pkg::row_t'(1) << (cur_col_reg + bmc_pkg::pos_t'(1));

    assign st_col = (int'(cmd.start_col) > bmc_pkg::N - 1) ?
                    bmc_pkg::pos_t'(bmc_pkg::N - 1) : bmc_pkg::pos_t'(cmd.start_col);
    assign st_row = (int'(cmd.start_row) > bmc_pkg::N - 1) ?
                    bmc_pkg::pos_t'(bmc_pkg::N - 1) : bmc_pkg::pos_t'(cmd.start_row);

    assign up_free = !at_top && !row_up_reg[cur_col_reg];
    assign dn_free = !at_bot && !row_dn_reg[cur_col_reg];
    assign lf_free = !at_lft && !row_cur_reg[cur_col_reg - bmc_pkg::pos_t'(1)];
    assign rt_free = !at_rgt && !row_cur_reg[cur_col_reg + bmc_pkg::pos_t'(1)];

    always_comb
    begin
        case (draw_reg)
            bmc_pkg::DIR_UP:
            begin
                drawn_free = up_free;
                nb_row     = row_up;
                nb_col     = cur_col_reg;
                vis_wdata  = row_up_reg | col_oh;
            end
            bmc_pkg::DIR_DOWN:
            begin
                drawn_free = dn_free;
                nb_row     = row_dn;
                nb_col     = cur_col_reg;
                vis_wdata  = row_dn_reg | col_oh;
            end
            bmc_pkg::DIR_LEFT:
            begin
                drawn_free = lf_free;
                nb_row     = cur_row_reg;
                nb_col     = cur_col_reg - bmc_pkg::pos_t'(1);
                vis_wdata  = row_cur_reg | lf_oh;
            end
            default:
            begin
                drawn_free = rt_free;
                nb_row     = cur_row_reg;
                nb_col     = cur_col_reg + bmc_pkg::pos_t'(1);
                vis_wdata  = row_cur_reg | rt_oh;
            end
        endcase
        vis_we    = ctl.move;
        vis_waddr = nb_row;
        if (ctl.start)
        begin
            vis_we    = 1'b1;
            vis_waddr = st_row;
            vis_wdata = bmc_pkg::row_t'(1) << st_col;
        end
    end

    // opening goes into the upper or left cell of the pair
    assign open_waddr = (draw_reg == bmc_pkg::DIR_UP) ? row_up : cur_row_reg;
    assign dwn_we     = ctl.move &&
                        (draw_reg == bmc_pkg::DIR_UP || draw_reg == bmc_pkg::DIR_DOWN);
    assign rgt_we     = ctl.move &&
                        (draw_reg == bmc_pkg::DIR_LEFT || draw_reg == bmc_pkg::DIR_RIGHT);
    assign dwn_wdata  = dwn_row | col_oh;
    assign rgt_wdata  = rgt_row | ((draw_reg == bmc_pkg::DIR_LEFT) ? lf_oh : col_oh);

    always_comb
    begin
        case (ctl.map_rd)
            bmc_pkg::RD_CUR:  map_raddr = cur_row_reg;
            bmc_pkg::RD_UP:   map_raddr = at_top ? cur_row_reg : row_up;
            bmc_pkg::RD_DN:   map_raddr = at_bot ? cur_row_reg : row_dn;
            bmc_pkg::RD_OPEN: map_raddr = open_waddr;
            bmc_pkg::RD_BM:   map_raddr = bm_r_reg;
            default:          map_raddr = cur_row_reg;
        endcase
    end
    assign map_re = (ctl.map_rd != bmc_pkg::RD_NONE);

    assign depth_dec = depth_reg - bmc_pkg::cnt_t'(1);
    assign stk_we    = ctl.move && (depth_reg < bmc_pkg::cnt_t'(bmc_pkg::NCELLS));

    bmc_ram #(.WIDTH(bmc_pkg::N), .DEPTH(bmc_pkg::N)) u_vis_ram (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (vis_rdata)
    );

    bmc_ram #(.WIDTH(bmc_pkg::N), .DEPTH(bmc_pkg::N)) u_rgt_ram (
        .clk   (clk),
        .we    (rgt_we),
        .waddr (open_waddr),
        .wdata (rgt_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (rgt_rdata)
    );

    bmc_ram #(.WIDTH(bmc_pkg::N), .DEPTH(bmc_pkg::N)) u_dwn_ram (
        .clk   (clk),
        .we    (dwn_we),
        .waddr (open_waddr),
        .wdata (dwn_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (dwn_rdata)
    );

    bmc_ram #(.WIDTH(bmc_pkg::CELL_W), .DEPTH(bmc_pkg::NCELLS)) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (depth_reg[bmc_pkg::CELL_W-1:0]),
        .wdata ({cur_row_reg, cur_col_reg}),
        .re    (ctl.stk_rd),
        .raddr (depth_dec[bmc_pkg::CELL_W-1:0]),
        .rdata (stk_rdata)
    );

    assign idx_odd  = {1'b0, bm_r_reg, 1'b1};
    assign idx_even = idx_odd + 1'b1;

    always_comb
    begin
        out_next           = out_reg;
        out_next.status    = bmc_pkg::ST_MOVED;
        out_next.cur_col   = bmc_pkg::coord_t'(cur_col_reg);
        out_next.cur_row   = bmc_pkg::coord_t'(cur_row_reg);
        out_next.finished  = sts.finished;
        out_next.kind      = bmc_pkg::KIND_ROW;
        out_next.row_index = '0;
        out_next.row_bits  = '0;
        out_next.last      = 1'b0;
        case (ctl.emit)
            bmc_pkg::EM_REPORT:
            begin
                out_next.kind   = bmc_pkg::KIND_REPORT;
                out_next.status = ctl.status;
                out_next.last   = ctl.last;
            end
            bmc_pkg::EM_ODD:
            begin
                out_next.row_index = bmc_pkg::gidx_t'(idx_odd);
                out_next.row_bits  = bmc_pkg::odd_row(vis_row, rgt_row);
            end
            bmc_pkg::EM_EVEN:
            begin
                out_next.row_index = bmc_pkg::gidx_t'(idx_even);
                out_next.row_bits  = sts.bm_last ? '0 : bmc_pkg::even_row(dwn_row);
                out_next.last      = sts.bm_last;
            end
            default:
            begin
                out_next.row_index = '0;
            end
        endcase
    end

    assign sts.active    = active_reg;
    assign sts.any_free  = up_free || dn_free || lf_free || rt_free;
    assign sts.blocked   = !drawn_free;
    assign sts.stk_empty = (depth_reg == '0);
    assign sts.finished  = (cnt_reg == bmc_pkg::cnt_t'(bmc_pkg::NCELLS));
    assign sts.slot_free = !out_vld_reg || !rpt_stall;
    assign sts.bm_last   = (bm_r_reg == bmc_pkg::pos_t'(bmc_pkg::N - 1));

    assign rpt_valid = out_vld_reg;
    assign rpt       = out_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            cnt_reg     <= '0;
            depth_reg   <= '0;
            active_reg  <= 1'b0;
            vis_vld_reg <= '0;
            rgt_vld_reg <= '0;
            dwn_vld_reg <= '0;
            bm_r_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.start)
            begin
                cur_row_reg <= st_row;
                cur_col_reg <= st_col;
                cnt_reg     <= bmc_pkg::cnt_t'(1);
                depth_reg   <= '0;
                active_reg  <= 1'b1;
                vis_vld_reg <= bmc_pkg::row_t'(1) << st_row;
                rgt_vld_reg <= '0;
                dwn_vld_reg <= '0;
            end
            else
            begin
                if (vis_we)
                begin
                    vis_vld_reg[vis_waddr] <= 1'b1;
                end
                if (rgt_we)
                begin
                    rgt_vld_reg[open_waddr] <= 1'b1;
                end
                if (dwn_we)
                begin
                    dwn_vld_reg[open_waddr] <= 1'b1;
                end
            end
            if (ctl.move)
            begin
                cur_row_reg <= nb_row;
                cur_col_reg <= nb_col;
                cnt_reg     <= cnt_reg + bmc_pkg::cnt_t'(1);
                if (stk_we)
                begin
                    depth_reg <= depth_reg + bmc_pkg::cnt_t'(1);
                end
                if (cnt_reg == bmc_pkg::cnt_t'(bmc_pkg::NCELLS - 1))
                begin
                    active_reg <= 1'b0;
                end
            end
            if (ctl.pop)
            begin
                {cur_row_reg, cur_col_reg} <= stk_rdata;
                depth_reg                  <= depth_dec;
            end
            if (ctl.bm_clr)
            begin
                bm_r_reg <= '0;
            end
            else if (ctl.bm_inc)
            begin
                bm_r_reg <= bm_r_reg + bmc_pkg::pos_t'(1);
            end
            if (ctl.emit != bmc_pkg::EM_NONE)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!rpt_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            draw_reg <= cmd.draw;
        end
        case (ctl.cap)
            bmc_pkg::CAP_CUR: row_cur_reg <= vis_row;
            bmc_pkg::CAP_UP:  row_up_reg  <= vis_row;
            bmc_pkg::CAP_DN:  row_dn_reg  <= vis_row;
            default:          row_cur_reg <= row_cur_reg;
        endcase
        if (map_re)
        begin
            vis_v_reg <= vis_vld_reg[map_raddr];
            rgt_v_reg <= rgt_vld_reg[map_raddr];
            dwn_v_reg <= dwn_vld_reg[map_raddr];
        end
        if (ctl.emit != bmc_pkg::EM_NONE)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- rtl/backtracking_maze_carver.sv -----
// top level of the depth-first maze carver
//
//  channel  handshake             payload                 direction
//  cmd      cmd_valid/cmd_stall   bmc_in_t  (one item)    into the block
//  rpt      rpt_valid/rpt_stall   bmc_out_t (results)     out of the block
//
// one item at a time; a start item goes straight to its report, a step item
// runs three visited-row reads of one map port, decide, then a stack pop, a
// read-modify-write of an opening row or neither. the completing step adds one
// top row and, per cell row of readout, one map read and two emitted rows.
// reset clears position, counters and the row valid bits; no memory sweep.
// a stalled result holds in the output register; the next item is taken
// meanwhile and waits only when it has its own result to hand over.
`timescale 1ns / 1ps

module backtracking_maze_carver (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  bmc_pkg::bmc_in_t  cmd,
    output logic              rpt_valid,
    input  logic              rpt_stall,
    output bmc_pkg::bmc_out_t rpt
);

    bmc_pkg::bmc_ctl_t ctl;
    bmc_pkg::bmc_sts_t sts;

    bmc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_opcode (cmd.opcode),
        .cmd_stall  (cmd_stall),
        .sts        (sts),
        .ctl        (ctl)
    );

    bmc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rpt_stall (rpt_stall),
        .rpt_valid (rpt_valid),
        .rpt       (rpt),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule
